/* rtl/gbte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gbte_pkg;

  // default store size in bytes
  localparam int CAPACITY_DEF = 4096;

  // field widths of the command and result ports
  localparam int OP_W     = 3;
  localparam int CH_W     = 8;
  localparam int AMOUNT_W = 14;
  localparam int POS_W    = 13;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 13;

  // depth of the request queue between front and back
  localparam int QDEPTH = 2;

  // command codes on in_op
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_BACK = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FWD  = 3'd2;
  localparam logic [OP_W-1:0] OP_MOVE     = 3'd3;
  localparam logic [OP_W-1:0] OP_SET      = 3'd4;

  // status codes on out_status
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // classified request kind
  typedef enum logic [2:0] {
    K_INSERT,
    K_DEL_BACK,
    K_DEL_FWD,
    K_MOVE,
    K_SET,
    K_NOP
  } kind_t;

  // one classified request as it travels through the queue
  typedef struct packed {
    kind_t                       kind;
    logic                        needs_gap;
    logic [CH_W-1:0]             ch;
    logic signed [AMOUNT_W-1:0]  amount;
    logic [AMOUNT_W-1:0]         count;
    logic [POS_W-1:0]            position;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_RD,
    B_WR,
    B_EXEC
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/gap_buffer_text_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Gap-buffer text store of CAPACITY bytes with an editing cursor.
// Requests: drive in_op, in_ch, in_amount, in_position with start high; the
// request is taken at a clock edge where busy is low. A two-entry queue sits
// behind the request port, so busy rises only when two requests wait.
// Results: out_valid is high for one cycle with out_status, out_text_length
// and out_cursor; there is no backpressure, the result must be taken then.
// Path: a move, set, refused insert or edit with the gap already at the cursor
// goes from the queue through IDLE, CHECK and EXEC; the result strobe is
// registered from EXEC. An edit that first brings the gap to the cursor runs
// RD, WR and CHECK once more per byte copied across the gap (registered read).
// The back end works one request at a time; the queue holds the next ones.
// Reset (synchronous, rst_n low): empty text, cursor 0, queue empty, no
// result pending; store contents stay unknown and are never read unwritten.

module gap_buffer_text_engine import gbte_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [OP_W-1:0]            in_op,
  input  wire logic [CH_W-1:0]            in_ch,
  input  wire logic signed [AMOUNT_W-1:0] in_amount,
  input  wire logic [POS_W-1:0]           in_position,
  output logic                            out_valid,
  output logic [STATUS_W-1:0]             out_status,
  output logic [LEN_W-1:0]                out_text_length,
  output logic [LEN_W-1:0]                out_cursor
);

  logic push, pop, q_full, q_valid;
  cmd_t push_cmd, q_cmd;

  // request decode
  gbte_front u_front (
    .start       (start),
    .in_op       (in_op),
    .in_ch       (in_ch),
    .in_amount   (in_amount),
    .in_position (in_position),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // request queue
  gbte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // gap move and edit execution
  gbte_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_text_length (out_text_length),
    .out_cursor      (out_cursor)
  );

endmodule

`default_nettype wire

/* rtl/gbte_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbte_front import gbte_pkg::*; (
  input  wire logic                       start,
  input  wire logic [OP_W-1:0]            in_op,
  input  wire logic [CH_W-1:0]            in_ch,
  input  wire logic signed [AMOUNT_W-1:0] in_amount,
  input  wire logic [POS_W-1:0]           in_position,
  input  wire logic                       q_full,
  output logic                            busy,
  output logic                            push,
  output cmd_t                            push_cmd
);

  // a request is taken whenever the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // classify the request and precompute the delete count
  always_comb begin
    push_cmd.ch        = in_ch;
    push_cmd.amount    = in_amount;
    push_cmd.position  = in_position;
    push_cmd.count     = in_amount[AMOUNT_W-1] ? AMOUNT_W'(~in_amount + 1'b1)
                                               : in_amount;
    push_cmd.kind      = K_NOP;
    push_cmd.needs_gap = 1'b0;
    unique case (in_op)
      OP_INSERT: begin
        push_cmd.kind      = K_INSERT;
        push_cmd.needs_gap = 1'b1;
      end
      OP_DEL_BACK: begin
        push_cmd.kind      = K_DEL_BACK;
        push_cmd.needs_gap = 1'b1;
      end
      OP_DEL_FWD: begin
        push_cmd.kind      = K_DEL_FWD;
        push_cmd.needs_gap = 1'b1;
      end
      OP_MOVE: push_cmd.kind = K_MOVE;
      OP_SET:  push_cmd.kind = K_SET;
      default: push_cmd.kind = K_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/gbte_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbte_queue import gbte_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW  = $clog2(QDEPTH + 1);

  cmd_t            slot_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // request storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/gbte_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbte_back import gbte_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire cmd_t               q_cmd,
  output logic                    pop,
  output logic                    out_valid,
  output logic [STATUS_W-1:0]     out_status,
  output logic [LEN_W-1:0]        out_text_length,
  output logic [LEN_W-1:0]        out_cursor
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = ((PW > AMOUNT_W) ? PW : AMOUNT_W) + 1;
  localparam int SW = XW + 1;
  localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;

  logic [PW-1:0] gap_first_r, gap_first_nxt;
  logic [PW-1:0] gap_after_r, gap_after_nxt;
  logic [PW-1:0] cursor_r, cursor_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [LEN_W-1:0]    len_out_r, len_out_nxt;
  logic [LEN_W-1:0]    cur_out_r, cur_out_nxt;

  // text store with one write and one registered read port
  logic [CH_W-1:0] mem [CAPACITY];
  logic [CH_W-1:0] rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [CH_W-1:0] mem_wd;

  // derived values
  logic [PW-1:0]        len, avail_fwd, gf_dec, ga_dec, res_len;
  logic                 full, move_back, need_move;
  logic [XW-1:0]        cnt_x;
  logic [PW-1:0]        take_back, take_fwd, move_pos, set_pos;
  logic signed [SW-1:0] tgt, len_s;

  assign len       = gap_first_r + (CAP_W - gap_after_r);
  assign avail_fwd = CAP_W - gap_after_r;
  assign full      = (len == CAP_W);
  assign gf_dec    = gap_first_r - 1'b1;
  assign ga_dec    = gap_after_r - 1'b1;
  assign move_back = (cursor_r < gap_first_r);
  assign need_move = cmd_r.needs_gap && !(cmd_r.kind == K_INSERT && full)
                     && (cursor_r != gap_first_r);

  // delete counts clamped at the text ends
  assign cnt_x     = XW'(cmd_r.count);
  assign take_back = (cnt_x > XW'(gap_first_r)) ? gap_first_r : cnt_x[PW-1:0];
  assign take_fwd  = (cnt_x > XW'(avail_fwd)) ? avail_fwd : cnt_x[PW-1:0];

  // cursor targets clamped to 0..length
  assign len_s    = signed'(SW'(len));
  assign tgt      = signed'(SW'(cursor_r)) + SW'(cmd_r.amount);
  assign move_pos = (tgt < 0) ? '0 : ((tgt > len_s) ? len : tgt[PW-1:0]);
  assign set_pos  = (XW'(cmd_r.position) > XW'(len)) ? len : PW'(cmd_r.position);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (q_valid) state_nxt = B_CHECK;
      B_CHECK: state_nxt = need_move ? B_RD : B_EXEC;
      B_RD:    state_nxt = B_WR;
      B_WR:    state_nxt = B_CHECK;
      B_EXEC:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and memory control per state
  always_comb begin
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = gap_first_r[AW-1:0];
    mem_ra        = gap_after_r[AW-1:0];
    mem_wd        = rd_data_r;
    gap_first_nxt = gap_first_r;
    gap_after_nxt = gap_after_r;
    cursor_nxt    = cursor_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      B_IDLE: pop = q_valid;
      B_CHECK: ;
      // fetch the byte that crosses the gap
      B_RD: begin
        mem_re = 1'b1;
        mem_ra = move_back ? gf_dec[AW-1:0] : gap_after_r[AW-1:0];
      end
      // drop it on the other side and shift the gap by one
      B_WR: begin
        mem_we = 1'b1;
        if (move_back) begin
          mem_wa        = ga_dec[AW-1:0];
          gap_first_nxt = gf_dec;
          gap_after_nxt = ga_dec;
        end else begin
          mem_wa        = gap_first_r[AW-1:0];
          gap_first_nxt = gap_first_r + 1'b1;
          gap_after_nxt = gap_after_r + 1'b1;
        end
      end
      // carry out the edit or cursor change
      B_EXEC: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_DONE;
        unique case (cmd_r.kind)
          K_INSERT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we        = 1'b1;
              mem_wa        = gap_first_r[AW-1:0];
              mem_wd        = cmd_r.ch;
              gap_first_nxt = gap_first_r + 1'b1;
              cursor_nxt    = cursor_r + 1'b1;
            end
          end
          K_DEL_BACK: begin
            if (gap_first_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              gap_first_nxt = gap_first_r - take_back;
              cursor_nxt    = gap_first_r - take_back;
            end
          end
          K_DEL_FWD: begin
            if (avail_fwd == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              gap_after_nxt = gap_after_r + take_fwd;
            end
          end
          K_MOVE:  cursor_nxt = move_pos;
          K_SET:   cursor_nxt = set_pos;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result fields follow the updated gap and cursor
  assign res_len     = gap_first_nxt + (CAP_W - gap_after_nxt);
  assign len_out_nxt = (state_r == B_EXEC) ? LEN_W'(res_len) : len_out_r;
  assign cur_out_nxt = (state_r == B_EXEC) ? LEN_W'(cursor_nxt) : cur_out_r;

  // control and gap registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      gap_first_r <= '0;
      gap_after_r <= CAP_W;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gap_first_r <= gap_first_nxt;
      gap_after_r <= gap_after_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_cmd;
    end
    status_r  <= status_nxt;
    len_out_r <= len_out_nxt;
    cur_out_r <= cur_out_nxt;
  end

  // text store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_text_length = len_out_r;
  assign out_cursor      = cur_out_r;

endmodule

`default_nettype wire
